### hw/rtl/csrd_pkg.sv
package csrd_pkg;

    // Operand store: four high sums, four low sums, eight scratch entries
    localparam int RF_DEPTH = 16;
    localparam int RF_AW    = 4;

    // Arithmetic operations of the shared unit
    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_MOV
    } t_op;

    // Operand and destination codes used by the microprogram
    typedef logic [4:0] t_src;

    localparam t_src RH0    = 5'd0;
    localparam t_src RH1    = 5'd1;
    localparam t_src RH2    = 5'd2;
    localparam t_src RH3    = 5'd3;
    localparam t_src RL0    = 5'd4;
    localparam t_src RL1    = 5'd5;
    localparam t_src RL2    = 5'd6;
    localparam t_src RL3    = 5'd7;
    localparam t_src T0     = 5'd8;
    localparam t_src T1     = 5'd9;
    localparam t_src T2     = 5'd10;
    localparam t_src T3     = 5'd11;
    localparam t_src T4     = 5'd12;
    localparam t_src T5     = 5'd13;
    localparam t_src T6     = 5'd14;
    localparam t_src SRC_A  = 5'd16;
    localparam t_src SRC_B  = 5'd17;
    localparam t_src SRC_C  = 5'd18;
    localparam t_src SRC_HK = 5'd19;
    localparam t_src SRC_LK = 5'd20;

    // Microprogram entry points
    localparam logic [6:0] PC_ACC = 7'd0;
    localparam logic [6:0] PC_RED = 7'd39;

    // binary64 constants
    localparam logic [63:0] SPLIT_FACTOR = 64'h4190_0000_0400_0000;  // 2^26 + 1
    localparam logic [63:0] DEFAULT_NAN  = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] QUIET_BIT    = 64'h0008_0000_0000_0000;

    typedef struct packed {
        t_op  op;
        t_src src_a;
        t_src src_b;
        t_src dst;
        logic acc_end;
        logic emit;
    } t_uop;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_WAIT,
        S_OUT
    } t_seq_state;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_ADD,
        F_LZC,
        F_SHIFT,
        F_ROUND,
        F_DONE
    } t_fpu_state;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_fpu_req;

    typedef struct packed {
        logic done;
    } t_fpu_rsp;

    function automatic t_uop mk_uop(input t_op op, input t_src a, input t_src b,
                                    input t_src d);
        t_uop u;
        u.op      = op;
        u.src_a   = a;
        u.src_b   = b;
        u.dst     = d;
        u.acc_end = 1'b0;
        u.emit    = 1'b0;
        return u;
    endfunction

    // Seven-step error-free sum: s <- fl(s+e), e <- error
    function automatic t_uop ts_uop(input t_src s, input t_src e,
                                    input logic [6:0] pc, input logic [6:0] base);
        logic [6:0] step;
        t_uop       u;
        step = pc - base;
        case (step[2:0])
            3'd0:    u = mk_uop(OP_ADD, s,  e,  T1);
            3'd1:    u = mk_uop(OP_SUB, T1, s,  T2);
            3'd2:    u = mk_uop(OP_SUB, T1, T2, T3);
            3'd3:    u = mk_uop(OP_SUB, s,  T3, T3);
            3'd4:    u = mk_uop(OP_SUB, e,  T2, T2);
            3'd5:    u = mk_uop(OP_ADD, T3, T2, e);
            3'd6:    u = mk_uop(OP_MOV, T1, T1, s);
            default: u = mk_uop(OP_MOV, T1, T1, T1);
        endcase
        return u;
    endfunction

    // Microprogram: element accumulation, then row reduction
    function automatic t_uop uop_rom(input logic [6:0] pc);
        t_uop u;
        u = mk_uop(OP_MOV, T0, T0, T0);
        if (pc < 7'd17) begin
            case (pc)
                7'd0:    u = mk_uop(OP_MUL, SRC_A, SRC_B, T0);
                7'd1:    u = mk_uop(OP_MUL, SRC_A, SRC_C, T1);
                7'd2:    u = mk_uop(OP_SUB, T1, SRC_A, T2);
                7'd3:    u = mk_uop(OP_SUB, T1, T2, T2);
                7'd4:    u = mk_uop(OP_SUB, SRC_A, T2, T3);
                7'd5:    u = mk_uop(OP_MUL, SRC_B, SRC_C, T1);
                7'd6:    u = mk_uop(OP_SUB, T1, SRC_B, T4);
                7'd7:    u = mk_uop(OP_SUB, T1, T4, T4);
                7'd8:    u = mk_uop(OP_SUB, SRC_B, T4, T5);
                7'd9:    u = mk_uop(OP_MUL, T2, T4, T1);
                7'd10:   u = mk_uop(OP_SUB, T0, T1, T1);
                7'd11:   u = mk_uop(OP_MUL, T3, T4, T6);
                7'd12:   u = mk_uop(OP_SUB, T1, T6, T1);
                7'd13:   u = mk_uop(OP_MUL, T2, T5, T6);
                7'd14:   u = mk_uop(OP_SUB, T1, T6, T1);
                7'd15:   u = mk_uop(OP_MUL, T3, T5, T6);
                7'd16:   u = mk_uop(OP_SUB, T6, T1, T5);
                default: u = mk_uop(OP_MOV, T0, T0, T0);
            endcase
        end else if (pc < 7'd24) begin
            u = ts_uop(SRC_HK, T0, pc, 7'd17);
        end else if (pc < 7'd31) begin
            u = ts_uop(T0, T5, pc, 7'd24);
        end else if (pc < 7'd38) begin
            u = ts_uop(SRC_LK, T0, pc, 7'd31);
        end else if (pc == 7'd38) begin
            u = mk_uop(OP_ADD, SRC_LK, T5, SRC_LK);
            u.acc_end = 1'b1;
        end else if (pc < 7'd46) begin
            u = ts_uop(RH0, RH1, pc, 7'd39);
        end else if (pc < 7'd53) begin
            u = ts_uop(RH2, RH3, pc, 7'd46);
        end else if (pc < 7'd60) begin
            u = ts_uop(RH0, RH2, pc, 7'd53);
        end else if (pc < 7'd67) begin
            u = ts_uop(RL0, RL1, pc, 7'd60);
        end else if (pc < 7'd74) begin
            u = ts_uop(RL2, RL3, pc, 7'd67);
        end else if (pc < 7'd81) begin
            u = ts_uop(RL0, RL2, pc, 7'd74);
        end else if (pc < 7'd88) begin
            u = ts_uop(RH1, RH2, pc, 7'd81);
        end else if (pc < 7'd95) begin
            u = ts_uop(RH3, RL0, pc, 7'd88);
        end else if (pc < 7'd102) begin
            u = ts_uop(RH1, RH3, pc, 7'd95);
        end else begin
            u = mk_uop(OP_ADD, RH0, RH1, T0);
            u.emit = 1'b1;
        end
        return u;
    endfunction

endpackage

### hw/rtl/csrd_ram.sv
module csrd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

### hw/rtl/csrd_fpu.sv
module csrd_fpu import csrd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_fpu_req    i_req,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output t_fpu_rsp    o_rsp,
    output logic [63:0] o_result
);

    t_fpu_state r_state;
    t_fpu_state n_state;

    logic [52:0]        r_ma;
    logic [55:0]        r_mb;
    logic [11:0]        r_d;
    logic               r_sub;
    logic signed [13:0] r_x;
    logic               r_sign;
    logic               r_zsign;
    logic [127:0]       r_sig;
    logic [1:0]         r_cnt;
    logic [6:0]         r_p;
    logic               r_zero;
    logic [52:0]        r_mant;
    logic               r_g;
    logic               r_s;
    logic signed [13:0] r_eeff;
    logic [63:0]        r_result;

    // operand unpack
    logic        sa, sb;
    logic [10:0] ea_f, eb_f, ea, eb;
    logic [52:0] ma, mb;
    logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic        a_ge_b;
    logic        special;
    logic [63:0] special_val;
    logic signed [13:0] mul_x, add_x;

    always_comb begin
        sa     = i_a[63];
        sb     = (i_req.op == OP_SUB) ? ~i_b[63] : i_b[63];
        ea_f   = i_a[62:52];
        eb_f   = i_b[62:52];
        ma     = {ea_f != 11'd0, i_a[51:0]};
        mb     = {eb_f != 11'd0, i_b[51:0]};
        ea     = (ea_f == 11'd0) ? 11'd1 : ea_f;
        eb     = (eb_f == 11'd0) ? 11'd1 : eb_f;
        nan_a  = (ea_f == 11'h7FF) && (i_a[51:0] != 52'd0);
        nan_b  = (eb_f == 11'h7FF) && (i_b[51:0] != 52'd0);
        inf_a  = (ea_f == 11'h7FF) && (i_a[51:0] == 52'd0);
        inf_b  = (eb_f == 11'h7FF) && (i_b[51:0] == 52'd0);
        zero_a = (i_a[62:0] == 63'd0);
        zero_b = (i_b[62:0] == 63'd0);
        a_ge_b = {ea, ma} >= {eb, mb};
        mul_x  = signed'({3'b000, ea}) + signed'({3'b000, eb}) - 14'sd1075;
        add_x  = signed'({3'b000, (a_ge_b ? ea : eb)}) - 14'sd3;

        // NaN, infinity and invalid cases; first NaN operand wins
        special     = 1'b1;
        special_val = DEFAULT_NAN;
        if (nan_a) begin
            special_val = i_a | QUIET_BIT;
        end else if (nan_b) begin
            special_val = i_b | QUIET_BIT;
        end else if (i_req.op == OP_MUL) begin
            if ((inf_a && zero_b) || (zero_a && inf_b)) begin
                special_val = DEFAULT_NAN;
            end else if (inf_a || inf_b) begin
                special_val = {sa ^ sb, 11'h7FF, 52'd0};
            end else begin
                special = 1'b0;
            end
        end else begin
            if (inf_a && inf_b && (sa != sb)) begin
                special_val = DEFAULT_NAN;
            end else if (inf_a) begin
                special_val = i_a;
            end else if (inf_b) begin
                special_val = {sb, 11'h7FF, 52'd0};
            end else begin
                special = 1'b0;
            end
        end
    end

    // partial product, 14 bits of the multiplier per cycle
    logic [13:0]  chunk;
    logic [66:0]  pp;
    logic [127:0] pp_shift;

    always_comb begin
        case (r_cnt)
            2'd0:    chunk = r_mb[13:0];
            2'd1:    chunk = r_mb[27:14];
            2'd2:    chunk = r_mb[41:28];
            2'd3:    chunk = r_mb[55:42];
            default: chunk = r_mb[13:0];
        endcase
        pp       = r_ma * chunk;
        pp_shift = {61'd0, pp} << ({5'd0, r_cnt} * 7'd14);
    end

    // alignment and add with guard, round and sticky bits
    logic [55:0] big, sh, bx;
    logic        lost;
    logic [56:0] add_sum;

    always_comb begin
        big  = {r_mb[52:0], 3'b000};
        sh   = big >> r_d[5:0];
        lost = (sh << r_d[5:0]) != big;
        if (r_d >= 12'd56) begin
            bx = {55'd0, |r_mb[52:0]};
        end else begin
            bx = sh | {55'd0, lost};
        end
        add_sum = r_sub ? ({1'b0, r_ma, 3'b000} - {1'b0, bx})
                        : ({1'b0, r_ma, 3'b000} + {1'b0, bx});
    end

    // leading one position
    logic [6:0] lz_p;

    always_comb begin
        lz_p = 7'd0;
        for (int i = 0; i < 128; i++) begin
            if (r_sig[i]) begin
                lz_p = 7'(i);
            end
        end
    end

    // normalize, including gradual underflow
    logic signed [13:0] e_try, rsh, eeff, lsh;
    logic [127:0]       lwide;
    logic [255:0]       rwide;
    logic [52:0]        sh_mant;
    logic               sh_g, sh_s;

    always_comb begin
        e_try = r_x + signed'({7'd0, r_p}) - 14'sd52;
        if (e_try >= 14'sd1) begin
            rsh  = signed'({7'd0, r_p}) - 14'sd52;
            eeff = e_try;
        end else begin
            rsh  = 14'sd1 - r_x;
            eeff = 14'sd1;
        end
        lsh   = -rsh;
        lwide = r_sig << lsh[5:0];
        rwide = {r_sig, 128'd0} >> rsh[7:0];
        if (rsh < 14'sd0) begin
            sh_mant = lwide[52:0];
            sh_g    = 1'b0;
            sh_s    = 1'b0;
        end else if (rsh > 14'sd128) begin
            sh_mant = 53'd0;
            sh_g    = 1'b0;
            sh_s    = |r_sig;
        end else begin
            sh_mant = rwide[180:128];
            sh_g    = rwide[127];
            sh_s    = |rwide[126:0];
        end
    end

    // round to nearest even and pack
    logic               up;
    logic [53:0]        m2;
    logic [52:0]        mfin;
    logic signed [13:0] efin;
    logic [63:0]        packed_val;

    always_comb begin
        up = r_g & (r_s | r_mant[0]);
        m2 = {1'b0, r_mant} + {53'd0, up};
        if (m2[53]) begin
            mfin = m2[53:1];
            efin = r_eeff + 14'sd1;
        end else begin
            mfin = m2[52:0];
            efin = m2[52] ? r_eeff : 14'sd0;
        end
        if (r_zero) begin
            packed_val = {r_zsign, 63'd0};
        end else if (efin >= 14'sd2047) begin
            packed_val = {r_sign, 11'h7FF, 52'd0};
        end else begin
            packed_val = {r_sign, efin[10:0], mfin[51:0]};
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (i_req.start) begin
                    if (i_req.op == OP_MOV || special) begin
                        n_state = F_DONE;
                    end else if (i_req.op == OP_MUL) begin
                        n_state = F_MUL;
                    end else begin
                        n_state = F_ADD;
                    end
                end
            end
            F_MUL:   n_state = (r_cnt == 2'd3) ? F_LZC : F_MUL;
            F_ADD:   n_state = F_LZC;
            F_LZC:   n_state = F_SHIFT;
            F_SHIFT: n_state = F_ROUND;
            F_ROUND: n_state = F_DONE;
            F_DONE:  n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_rsp.done = (r_state == F_DONE);
        o_result   = r_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                r_sig <= 128'd0;
                r_cnt <= 2'd0;
                if (i_req.op == OP_MOV) begin
                    r_result <= i_a;
                end else begin
                    r_result <= special_val;
                end
                if (i_req.op == OP_MUL) begin
                    r_ma    <= ma;
                    r_mb    <= {3'b000, mb};
                    r_x     <= mul_x;
                    r_sign  <= sa ^ sb;
                    r_zsign <= sa ^ sb;
                end else begin
                    r_ma    <= a_ge_b ? ma : mb;
                    r_mb    <= {3'b000, (a_ge_b ? mb : ma)};
                    r_d     <= a_ge_b ? {1'b0, ea - eb} : {1'b0, eb - ea};
                    r_x     <= add_x;
                    r_sign  <= a_ge_b ? sa : sb;
                    r_zsign <= sa & sb;
                    r_sub   <= sa ^ sb;
                end
            end
            F_MUL: begin
                r_sig <= r_sig + pp_shift;
                r_cnt <= r_cnt + 2'd1;
            end
            F_ADD: begin
                r_sig <= {71'd0, add_sum};
            end
            F_LZC: begin
                r_p    <= lz_p;
                r_zero <= (r_sig == 128'd0);
            end
            F_SHIFT: begin
                r_mant <= sh_mant;
                r_g    <= sh_g;
                r_s    <= sh_s;
                r_eeff <= eeff;
            end
            F_ROUND: begin
                r_result <= packed_val;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

endmodule

### hw/rtl/compensated_sparse_row_dot.sv
// Each element runs 39 micro-operations on one shared binary64 unit (add, multiply and
// move); a row-closing request then adds lane reduction (64 operations) before the
// result is offered.
// Handshake: one request at a time; ready is high only while the sequencer is idle.
// Reset: synchronous active-low i_rst_n clears accumulators (via valid bits), lane, sequencer.
module compensated_sparse_row_dot import csrd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_matrix_value,
    input  logic [63:0] i_vector_value,
    input  logic        i_last_in_row,
    input  logic        i_row_empty,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_row_result
);

    t_seq_state r_state;
    t_seq_state n_state;

    logic [6:0]  r_pc;
    logic [1:0]  r_lane;
    logic [7:0]  r_valid;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic        r_last;
    logic [63:0] r_result;

    t_uop        uop;
    t_fpu_req    fpu_req;
    t_fpu_rsp    fpu_rsp;
    logic [63:0] fpu_y;
    logic [63:0] op_a, op_b;
    logic [63:0] rd_a, rd_b;
    logic [RF_AW-1:0] addr_a, addr_b, addr_d;
    logic        we;

    // map lane-relative codes to store addresses
    function automatic logic [RF_AW-1:0] map_addr(input t_src code, input logic [1:0] lane);
        logic [RF_AW-1:0] a;
        if (code == SRC_HK) begin
            a = {2'b00, lane};
        end else if (code == SRC_LK) begin
            a = {2'b01, lane};
        end else begin
            a = code[RF_AW-1:0];
        end
        return a;
    endfunction

    // operand source: latched request, split constant or store; invalid accumulators read as zero
    function automatic logic [63:0] pick(input t_src code, input logic [RF_AW-1:0] addr,
                                         input logic [63:0] rd, input logic [7:0] vld,
                                         input logic [63:0] a, input logic [63:0] b);
        logic [63:0] v;
        if (code == SRC_A) begin
            v = a;
        end else if (code == SRC_B) begin
            v = b;
        end else if (code == SRC_C) begin
            v = SPLIT_FACTOR;
        end else if (!addr[3] && !vld[addr[2:0]]) begin
            v = 64'd0;
        end else begin
            v = rd;
        end
        return v;
    endfunction

    always_comb begin
        uop    = uop_rom(r_pc);
        addr_a = map_addr(uop.src_a, r_lane);
        addr_b = map_addr(uop.src_b, r_lane);
        addr_d = map_addr(uop.dst, r_lane);
        op_a   = pick(uop.src_a, addr_a, rd_a, r_valid, r_a, r_b);
        op_b   = pick(uop.src_b, addr_b, rd_b, r_valid, r_a, r_b);
        fpu_req.start = (r_state == S_EXEC);
        fpu_req.op    = uop.op;
        we     = (r_state == S_WAIT) && fpu_rsp.done && !uop.emit;
    end

    csrd_ram #(
        .WIDTH (64),
        .DEPTH (RF_DEPTH)
    ) u_rf (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (addr_d),
        .i_wdata   (fpu_y),
        .i_raddr_a (addr_a),
        .i_raddr_b (addr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    csrd_fpu u_fpu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (fpu_req),
        .i_a      (op_a),
        .i_b      (op_b),
        .o_rsp    (fpu_rsp),
        .o_result (fpu_y)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_EXEC;
            S_EXEC: n_state = S_WAIT;
            S_WAIT: begin
                if (fpu_rsp.done) begin
                    if (uop.emit) begin
                        n_state = S_OUT;
                    end else if (uop.acc_end && !r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready   = (r_state == S_IDLE);
        o_out_valid  = (r_state == S_OUT);
        o_row_result = r_result;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= PC_ACC;
            r_lane  <= 2'd0;
            r_valid <= 8'd0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_in_valid) begin
                r_pc <= i_row_empty ? PC_RED : PC_ACC;
            end
            if (r_state == S_WAIT && fpu_rsp.done) begin
                if (uop.emit) begin
                    r_valid <= 8'd0;
                    r_lane  <= 2'd0;
                end else begin
                    if (!addr_d[3]) begin
                        r_valid[addr_d[2:0]] <= 1'b1;
                    end
                    if (uop.acc_end) begin
                        r_lane <= r_lane + 2'd1;
                        r_pc   <= PC_RED;
                    end else begin
                        r_pc <= r_pc + 7'd1;
                    end
                end
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_a    <= i_matrix_value;
            r_b    <= i_vector_value;
            r_last <= i_last_in_row;
        end
        if (r_state == S_WAIT && fpu_rsp.done && uop.emit) begin
            r_result <= fpu_y;
        end
    end

endmodule

### hw/rtl/csrd_checker.sv
module csrd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [63:0] i_matrix_value,
    input logic [63:0] i_vector_value,
    input logic        i_last_in_row,
    input logic        i_row_empty,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [63:0] o_row_result
);

    // never takes a request while a result is pending
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("ready and result valid both high");

    // busy after a request is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready stayed high after request");

    // idle again once the result is taken
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> o_in_ready)
        else $error("not ready after result taken");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_row_result)))
        else $error("stalled result changed");

endmodule

bind compensated_sparse_row_dot csrd_checker u_csrd_checker (.*);
